>>> rtl/cre_pkg.sv
`default_nettype none

package cre_pkg;

    localparam int BUFFER_BYTES_DEF = 4096;
    localparam int ID_BITS_DEF      = 16;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 13;
    localparam int CID_W      = 16;
    localparam int RIDX_W     = 12;
    localparam int STATUS_W   = 4;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [REQ_W-1:0] REQ_HEADER  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PAYLOAD = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 4'd0;
    localparam logic [STATUS_W-1:0] ST_COMPLETE   = 4'd1;
    localparam logic [STATUS_W-1:0] ST_WRONG_TYPE = 4'd2;
    localparam logic [STATUS_W-1:0] ST_NO_FRAME   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_ORDER      = 4'd4;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_STORED     = 4'd6;
    localparam logic [STATUS_W-1:0] ST_DROPPED    = 4'd7;
    localparam logic [STATUS_W-1:0] ST_READ       = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPTED_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT   = 2'd1;

    localparam logic [BYTE_W-1:0] ACCEPTED_TYPE_RST = 8'd0;
    localparam logic [LEN_W-1:0]  FRAME_LIMIT_RST   = 13'd4096;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [BYTE_W-1:0] pkt_type;
        logic [CID_W-1:0]  seq_no;
        logic [LEN_W-1:0]  seg_len;
        logic              start_flag;
        logic              end_flag;
        logic [BYTE_W-1:0] data_byte;
        logic [RIDX_W-1:0] read_index;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    frame_length;
        logic [BYTE_W-1:0]   read_data;
    } out_t;

endpackage

`default_nettype wire

>>> rtl/cre_store.sv
`default_nettype none

module cre_store #(
    parameter int DEPTH = cre_pkg::BUFFER_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [cre_pkg::BYTE_W-1:0] wr_data,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr,
    output logic      [cre_pkg::BYTE_W-1:0] rd_data
);
    import cre_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/chunk_reassembly_engine_unit.sv
`default_nettype none

// Chunk reassembly engine. Takes one item per clock on the s_ channel while the output
// is not stalled and gives one result per item on the m_ channel (an unused request
// code gives none); a result is registered in stage one at the transfer and moves to
// the m_ registers, raising m_valid, when the output is free. Header checks, byte
// counting and the chunk id sequence run in registers in the cycle of the transfer;
// payload bytes are written to and read bytes fetched from a single-port-per-direction
// byte store of BUFFER_BYTES entries whose read data is registered. Entries never
// written read back undefined. Configuration writes on cfg_wen take effect at once
// and are meant for idle periods only.

module chunk_reassembly_engine_unit #(
    parameter int BUFFER_BYTES = cre_pkg::BUFFER_BYTES_DEF,
    parameter int ID_BITS      = cre_pkg::ID_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire cre_pkg::in_t                  s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output cre_pkg::out_t                      m_data,
    input  wire logic                          cfg_wen,
    input  wire logic [cre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cre_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import cre_pkg::*;

    localparam int AW      = $clog2(BUFFER_BYTES);
    localparam int LIM_CAP = (BUFFER_BYTES > 8191) ? 8191 : BUFFER_BYTES;

    logic [BYTE_W-1:0]  accepted_type_reg;
    logic [LEN_W-1:0]   frame_limit_reg;

    logic [LEN_W-1:0]   frame_bytes_reg, frame_bytes_next;
    logic [ID_BITS-1:0] next_id_reg, next_id_next;
    logic               frame_open_reg, frame_open_next;
    logic [LEN_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [LEN_W-1:0]   pending_reg, pending_next;

    logic                p1_valid_reg;
    logic [STATUS_W-1:0] p1_status_reg;
    logic [LEN_W-1:0]    p1_len_reg;
    logic                p1_rsel_reg;

    logic                m_valid_reg;
    out_t                m_data_reg;

    logic                s_accept;
    logic                p1_adv;
    logic                res_valid;
    logic [STATUS_W-1:0] res_status;
    logic                res_rsel;
    logic                st_wen;
    logic                st_ren;
    logic [BYTE_W-1:0]   st_rdata;

    logic [LEN_W-1:0]    limit_eff;
    logic [LEN_W-1:0]    fb_v;
    logic [ID_BITS-1:0]  nid_v;
    logic                open_v;
    logic [LEN_W:0]      sum_v;
    logic [ID_BITS-1:0]  cid_m;

    assign p1_adv   = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !p1_valid_reg || p1_adv;
    assign s_accept = s_valid && s_ready;

    assign limit_eff = (frame_limit_reg > LEN_W'(LIM_CAP)) ? LEN_W'(LIM_CAP)
                                                           : frame_limit_reg;
    assign cid_m = ID_BITS'(s_data.seq_no);

    always_comb begin
        frame_bytes_next = frame_bytes_reg;
        next_id_next     = next_id_reg;
        frame_open_next  = frame_open_reg;
        wr_ptr_next      = wr_ptr_reg;
        pending_next     = pending_reg;
        res_valid        = 1'b0;
        res_status       = ST_READ;
        res_rsel         = 1'b0;
        st_wen           = 1'b0;
        st_ren           = 1'b0;
        fb_v             = s_data.start_flag ? '0 : frame_bytes_reg;
        nid_v            = s_data.start_flag ? '0 : next_id_reg;
        open_v           = s_data.start_flag | frame_open_reg;
        sum_v            = {1'b0, fb_v} + {1'b0, s_data.seg_len};
        if (s_accept) begin
            case (s_data.req_type)
                REQ_HEADER: begin
                    res_valid    = 1'b1;
                    pending_next = '0;
                    if (s_data.pkt_type != accepted_type_reg) begin
                        res_status = ST_WRONG_TYPE;
                    end else if (!open_v) begin
                        res_status = ST_NO_FRAME;
                    end else if (cid_m != nid_v) begin
                        frame_bytes_next = fb_v;
                        next_id_next     = nid_v;
                        frame_open_next  = 1'b0;
                        res_status       = ST_ORDER;
                    end else if (sum_v > {1'b0, limit_eff}) begin
                        frame_bytes_next = fb_v;
                        next_id_next     = nid_v;
                        frame_open_next  = 1'b0;
                        res_status       = ST_OVERFLOW;
                    end else begin
                        wr_ptr_next      = fb_v;
                        pending_next     = s_data.seg_len;
                        frame_bytes_next = sum_v[LEN_W-1:0];
                        next_id_next     = nid_v + ID_BITS'(1);
                        frame_open_next  = !s_data.end_flag;
                        res_status       = s_data.end_flag ? ST_COMPLETE : ST_ACCEPTED;
                    end
                end
                REQ_PAYLOAD: begin
                    res_valid = 1'b1;
                    if (pending_reg != '0 && 32'(wr_ptr_reg) < 32'(BUFFER_BYTES)) begin
                        st_wen       = 1'b1;
                        wr_ptr_next  = wr_ptr_reg + LEN_W'(1);
                        pending_next = pending_reg - LEN_W'(1);
                        res_status   = ST_STORED;
                    end else begin
                        res_status = ST_DROPPED;
                    end
                end
                REQ_READ: begin
                    res_valid  = 1'b1;
                    res_status = ST_READ;
                    if (32'(s_data.read_index) < 32'(BUFFER_BYTES)) begin
                        st_ren   = 1'b1;
                        res_rsel = 1'b1;
                    end
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    cre_store #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_wen),
        .wr_addr (AW'(wr_ptr_reg)),
        .wr_data (s_data.data_byte),
        .rd_en   (st_ren),
        .rd_addr (AW'(s_data.read_index)),
        .rd_data (st_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accepted_type_reg <= ACCEPTED_TYPE_RST;
            frame_limit_reg   <= FRAME_LIMIT_RST;
            frame_bytes_reg   <= '0;
            next_id_reg       <= '0;
            frame_open_reg    <= 1'b0;
            wr_ptr_reg        <= '0;
            pending_reg       <= '0;
            p1_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wen) begin
                case (cfg_index)
                    CFG_ACCEPTED_TYPE: accepted_type_reg <= cfg_wdata[BYTE_W-1:0];
                    CFG_FRAME_LIMIT:   frame_limit_reg   <= cfg_wdata[LEN_W-1:0];
                    default: begin
                        accepted_type_reg <= accepted_type_reg;
                    end
                endcase
            end
            frame_bytes_reg <= frame_bytes_next;
            next_id_reg     <= next_id_next;
            frame_open_reg  <= frame_open_next;
            wr_ptr_reg      <= wr_ptr_next;
            pending_reg     <= pending_next;
            if (s_accept) begin
                p1_valid_reg <= res_valid;
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // hold stage one while stalled so the store read data stays put
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_status_reg <= res_status;
            p1_len_reg    <= frame_bytes_next;
            p1_rsel_reg   <= res_rsel;
        end
        if (p1_adv) begin
            m_data_reg.status       <= p1_status_reg;
            m_data_reg.frame_length <= p1_len_reg;
            m_data_reg.read_data    <= p1_rsel_reg ? st_rdata : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
